// File: rtl/core/assert_macros.svh
// assertion macros for the top-level rtl file of the sorted table search block
// no dependencies; compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// checked property with reset disable
`define TSST_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: check failed");
// checked property, also active during reset
`define TSST_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("%m: check failed");
`else
`define TSST_ASSERT(label, clk, rst_n, prop)
`define TSST_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// File: rtl/core/tsst_pkg.sv
// shared types and constants of the sorted table search block
// no dependencies
package tsst_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned POS_W  = 11;
    localparam int unsigned CMD_W  = 2;

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic [CMD_W-1:0]         t_cmd;
    typedef logic [POS_W-1:0]         t_pos;

    localparam t_cmd CMD_CLEAR  = 2'd0;
    localparam t_cmd CMD_APPEND = 2'd1;
    localparam t_cmd CMD_SEARCH = 2'd2;

endpackage

// File: rtl/core/ternary_search_sorted_table.sv
// top level: sorted value table with ternary search lookup
// depends on tsst_pkg, tsst_table and assert_macros.svh
//
// Usage:
//   A transaction is taken at a rising edge with start high and busy low.
//   i_command selects clear (empties the table), append (stores i_value at
//   the next free position, ignored when the table is full) or search
//   (looks up i_value). Values are expected to be appended in ascending order.
//   Clear and append never raise busy, so they can be issued every cycle
//   while no search is busy; they produce no result.
//   A search raises busy and ends with a one-cycle pulse on o_valid carrying
//   o_found and the 1-based o_position (0 when not found). In each ternary
//   step S_PROBE forms both probe positions and reads the two entries from
//   the dual-read table, then S_CMP compares and narrows the window.
//   A hit shows after the step that finds it, a miss after the last step
//   and one more S_PROBE; a 1024-entry table needs at most 7 steps.
//   The next search can start in the cycle the result is shown.
//   Reset (synchronous, active low) empties the table and aborts a search;
//   table contents are not cleared. The receiver cannot stall results.
`include "assert_macros.svh"
module ternary_search_sorted_table #(
    parameter int unsigned DEPTH = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  tsst_pkg::t_cmd        i_command,
    input  tsst_pkg::t_data       i_value,
    output logic                  o_valid,
    output logic                  o_found,
    output tsst_pkg::t_pos        o_position
);

    localparam int unsigned AW = $clog2(DEPTH);
    // positions run up to DEPTH+1 while the window narrows
    localparam int unsigned PW = $clog2(DEPTH + 2);
    // floor(4^PW / 3) + 1: exact divide by three for any PW-bit value
    localparam logic [2*PW-1:0] RECIP3 = {PW{2'b01}} + (2*PW)'(1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PROBE = 2'd1;
    localparam logic [1:0] S_CMP   = 2'd2;

    logic [1:0]           r_state, n_state;
    logic [PW-1:0]        r_count, n_count;
    logic [PW-1:0]        r_lo, n_lo;
    logic [PW-1:0]        r_hi, n_hi;
    logic [PW-1:0]        r_p1, n_p1;
    logic [PW-1:0]        r_p2, n_p2;
    tsst_pkg::t_data      r_key, n_key;
    logic                 r_valid, n_valid;
    logic                 r_found, n_found;
    tsst_pkg::t_pos       r_pos, n_pos;

    logic                 tbl_we;
    logic [PW-1:0]        diff;
    logic [3*PW-1:0]      prod;
    logic [PW-1:0]        third;
    logic [PW-1:0]        p1_calc;
    logic [PW-1:0]        p2_calc;
    logic [PW-1:0]        p1_addr;
    logic [PW-1:0]        p2_addr;
    tsst_pkg::t_data      v1;
    tsst_pkg::t_data      v2;

    assign diff    = r_hi - r_lo;
    assign prod    = (3*PW)'(diff) * (3*PW)'(RECIP3);
    assign third   = prod[3*PW-1:2*PW];
    assign p1_calc = r_lo + third;
    assign p2_calc = r_hi - third;
    assign p1_addr = p1_calc - PW'(1);
    assign p2_addr = p2_calc - PW'(1);

    // writes happen only in idle, read data is used only while busy: no same-entry overlap
    tsst_table #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (tbl_we),
        .i_waddr   (r_count[AW-1:0]),
        .i_wdata   (i_value),
        .i_raddr_a (p1_addr[AW-1:0]),
        .i_raddr_b (p2_addr[AW-1:0]),
        .o_rdata_a (v1),
        .o_rdata_b (v2)
    );

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_p1    = r_p1;
        n_p2    = r_p2;
        n_key   = r_key;
        n_valid = 1'b0;
        n_found = r_found;
        n_pos   = r_pos;
        tbl_we  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (i_command)
                        tsst_pkg::CMD_CLEAR: begin
                            n_count = '0;
                        end
                        tsst_pkg::CMD_APPEND: begin
                            if (r_count < PW'(DEPTH)) begin
                                tbl_we  = 1'b1;
                                n_count = r_count + PW'(1);
                            end
                        end
                        tsst_pkg::CMD_SEARCH: begin
                            n_key   = i_value;
                            n_lo    = PW'(1);
                            n_hi    = r_count;
                            n_state = S_PROBE;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PROBE: begin
                if (r_lo > r_hi) begin
                    n_valid = 1'b1;
                    n_found = 1'b0;
                    n_pos   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_p1    = p1_calc;
                    n_p2    = p2_calc;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_PROBE;
                if (v1 == r_key) begin
                    n_valid = 1'b1;
                    n_found = 1'b1;
                    n_pos   = tsst_pkg::POS_W'(r_p1);
                    n_state = S_IDLE;
                end else if (v2 == r_key) begin
                    n_valid = 1'b1;
                    n_found = 1'b1;
                    n_pos   = tsst_pkg::POS_W'(r_p2);
                    n_state = S_IDLE;
                end else if (v1 > r_key) begin
                    n_hi = r_p1 - PW'(1);
                end else if (v2 < r_key) begin
                    n_lo = r_p2 + PW'(1);
                end else begin
                    n_lo = r_p1 + PW'(1);
                    n_hi = r_p2 - PW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_p1    <= n_p1;
        r_p2    <= n_p2;
        r_key   <= n_key;
        r_found <= n_found;
        r_pos   <= n_pos;
    end

    assign busy       = (r_state != S_IDLE);
    assign o_valid    = r_valid;
    assign o_found    = r_found;
    assign o_position = r_pos;

    `TSST_ASSERT(a_result_ends_search, i_clk, i_rst_n, o_valid |-> $past(r_state) != S_IDLE)
    `TSST_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= PW'(DEPTH))
    `TSST_ASSERT(a_miss_pos_zero, i_clk, i_rst_n, o_valid && !o_found |-> o_position == '0)
    `TSST_ASSERT(a_probe_window, i_clk, i_rst_n,
        r_state == S_CMP |-> r_p1 >= PW'(1) && r_p1 <= r_p2 && r_p2 <= r_count)
    `TSST_ASSERT(a_search_busy, i_clk, i_rst_n,
        start && !busy && i_command == tsst_pkg::CMD_SEARCH |=> busy)
    `TSST_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !busy && !o_valid)

endmodule

// File: rtl/core/tsst_table.sv
// value table: one write port, two registered read ports
// depends on tsst_pkg
module tsst_table #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  tsst_pkg::t_data      i_wdata,
    input  logic [AW-1:0]        i_raddr_a,
    input  logic [AW-1:0]        i_raddr_b,
    output tsst_pkg::t_data      o_rdata_a,
    output tsst_pkg::t_data      o_rdata_b
);

    tsst_pkg::t_data r_mem [DEPTH];
    tsst_pkg::t_data r_rdata_a;
    tsst_pkg::t_data r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule
